>>> design/gfpu_pkg.sv
// ----------------------------------------------------------------------------
// gfpu_pkg
// Types and constants shared by the gyro frame parser and its checker.
// ----------------------------------------------------------------------------
package gfpu_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h00;

  localparam int BODY_LEN = 13;
  localparam int SUM_LEN  = 11;
  localparam int CNT_W    = $clog2(BODY_LEN);

  localparam logic signed [16:0] UNWRAP_LIMIT = 17'sd18000;
  localparam logic [31:0]        TURN_UNITS   = 32'd36000;

  typedef logic [7:0]           rx_byte_t;
  typedef logic signed [15:0]   word_t;
  typedef logic signed [31:0]   angle32_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [1:0]           wsel_t;

  localparam cnt_t IDX_HEAD_HI = cnt_t'(2);
  localparam cnt_t IDX_X_HI    = cnt_t'(6);
  localparam cnt_t IDX_Y_HI    = cnt_t'(8);
  localparam cnt_t IDX_Z_HI    = cnt_t'(10);
  localparam cnt_t IDX_LAST    = cnt_t'(BODY_LEN - 1);

  localparam wsel_t W_HEAD = 2'd0;
  localparam wsel_t W_X    = 2'd1;
  localparam wsel_t W_Y    = 2'd2;
  localparam wsel_t W_Z    = 2'd3;

endpackage

>>> design/gyro_frame_parser_unwrap.sv
// ----------------------------------------------------------------------------
// gyro_frame_parser_unwrap
// Gyro serial frame parser with checksum check and multi-turn heading unwrap.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the output is not stalled, and
// every byte yields exactly one result transaction, through a flag stage and
// then the output register. The parser hunts for the header 0xAA 0x00 and
// writes the 13 body bytes into a small body memory with a registered read.
// When the high byte of a 16-bit field arrives, its low byte is read back from
// that memory and the assembled word is staged, so the checksum byte can commit
// all fields in the same cycle. The checksum runs as a byte sum while the
// body arrives. The turn count multiply sits between a flag stage and the
// output register, and the block stalls input only while that output register
// holds an untaken result.
module gyro_frame_parser_unwrap #(
  parameter int TURN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gfpu_pkg::rx_byte_t in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_done,
  output logic               out_checksum_ok,
  output gfpu_pkg::word_t    out_angle_out,
  output gfpu_pkg::word_t    out_accel_x,
  output gfpu_pkg::word_t    out_accel_y,
  output gfpu_pkg::word_t    out_accel_z,
  output gfpu_pkg::angle32_t out_unwrapped_angle
);
  import gfpu_pkg::*;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  logic [1:0]           phase_r, phase_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  logic [7:0]           sum_r, sum_nxt;
  rx_byte_t             body_mem [BODY_LEN];
  rx_byte_t             rdata_r;
  logic                 wr_en;
  logic                 rd_en;
  cnt_t                 rd_addr;
  rx_byte_t             hi_r, hi_nxt;
  wsel_t                sel_r, sel_nxt;
  logic                 pend_go_r;
  word_t                pend_r [4];
  word_t                head_r, head_nxt;
  word_t                ax_r, ax_nxt;
  word_t                ay_r, ay_nxt;
  word_t                az_r, az_nxt;
  logic [TURN_BITS-1:0] turn_r, turn_nxt;
  logic signed [16:0]   diff;
  logic                 accept;
  logic                 en;
  logic                 done;
  logic                 ok;
  logic                 s1_v_r, s1_done_r, s1_ok_r;
  logic                 out_v_r;
  angle32_t             turn_ext;
  logic [31:0]          prod;
  logic [31:0]          unw;

  assign en       = !out_v_r || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cnt_r - cnt_t'(1);
    hi_nxt    = hi_r;
    sel_nxt   = sel_r;
    done      = 1'b0;
    ok        = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_SECOND: begin
          if (in_rx_byte == HDR_SECOND) begin
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT;
            cnt_nxt   = '0;
          end
        end
        PH_BODY: begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + cnt_t'(1);
          if (cnt_r < cnt_t'(SUM_LEN)) begin
            sum_nxt = (cnt_r == '0) ? in_rx_byte : sum_r + in_rx_byte;
          end
          case (cnt_r)
            IDX_HEAD_HI: begin
              rd_en   = 1'b1;
              sel_nxt = W_HEAD;
            end
            IDX_X_HI: begin
              rd_en   = 1'b1;
              sel_nxt = W_X;
            end
            IDX_Y_HI: begin
              rd_en   = 1'b1;
              sel_nxt = W_Y;
            end
            IDX_Z_HI: begin
              rd_en   = 1'b1;
              sel_nxt = W_Z;
            end
            default: begin
            end
          endcase
          if (rd_en) begin
            hi_nxt = in_rx_byte;
          end
          if (cnt_r == IDX_LAST) begin
            done      = 1'b1;
            ok        = (sum_r == in_rx_byte);
            phase_nxt = PH_HUNT;
            cnt_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    head_nxt = head_r;
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    az_nxt   = az_r;
    turn_nxt = turn_r;
    diff     = 17'(pend_r[W_HEAD]) - 17'(head_r);
    if (ok) begin
      head_nxt = pend_r[W_HEAD];
      ax_nxt   = pend_r[W_X];
      ay_nxt   = pend_r[W_Y];
      az_nxt   = pend_r[W_Z];
      if (diff > UNWRAP_LIMIT) begin
        turn_nxt = turn_r - TURN_BITS'(1);
      end else if (diff < -UNWRAP_LIMIT) begin
        turn_nxt = turn_r + TURN_BITS'(1);
      end
    end
  end

  assign turn_ext = 32'(signed'(turn_r));
  assign prod     = turn_ext * TURN_UNITS;
  assign unw      = 32'd0 - (prod + 32'(head_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      body_mem[cnt_r] <= in_rx_byte;
    end
    if (rd_en) begin
      rdata_r <= body_mem[rd_addr];
    end
    if (pend_go_r) begin
      pend_r[sel_r] <= {hi_r, rdata_r};
    end
    sum_r <= sum_nxt;
    hi_r  <= hi_nxt;
    sel_r <= sel_nxt;
    if (en) begin
      s1_done_r <= done;
      s1_ok_r   <= ok;
    end
    if (en && s1_v_r) begin
      out_frame_done      <= s1_done_r;
      out_checksum_ok     <= s1_ok_r;
      out_angle_out       <= head_r;
      out_accel_x         <= ax_r;
      out_accel_y         <= ay_r;
      out_accel_z         <= az_r;
      out_unwrapped_angle <= angle32_t'(unw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      cnt_r     <= '0;
      pend_go_r <= 1'b0;
      head_r    <= '0;
      ax_r      <= '0;
      ay_r      <= '0;
      az_r      <= '0;
      turn_r    <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      pend_go_r <= rd_en;
      head_r    <= head_nxt;
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      az_r      <= az_nxt;
      turn_r    <= turn_nxt;
      if (en) begin
        s1_v_r  <= accept;
        out_v_r <= s1_v_r;
      end
    end
  end

  assign out_valid = out_v_r;

endmodule

>>> design/gfpu_chk.sv
// ----------------------------------------------------------------------------
// gfpu_chk
// Port-level checks of the gyro frame parser, bound to its top level.
// ----------------------------------------------------------------------------
module gfpu_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_frame_done,
  input logic               out_checksum_ok,
  input gfpu_pkg::word_t    out_angle_out,
  input gfpu_pkg::angle32_t out_unwrapped_angle
);
  import gfpu_pkg::*;

  word_t    last_ang_r;
  angle32_t last_unw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ang_r <= '0;
      last_unw_r <= '0;
    end else if (out_valid && out_ready) begin
      last_ang_r <= out_angle_out;
      last_unw_r <= out_unwrapped_angle;
    end
  end

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_frame_done)
    else $error("checksum_ok without frame_done");

  a_heading_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_checksum_ok |->
      out_unwrapped_angle == last_unw_r && out_angle_out == last_ang_r)
    else $error("heading changed without a good frame");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unwrapped_angle))
    else $error("stalled result transaction changed");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gyro_frame_parser_unwrap gfpu_chk u_gfpu_chk (.*);
